FILE: hdl/wrsd_pkg.sv
package wrsd_pkg;

    // Width of the running ratio correction, which stays in [1, 2^31 - 1].
    localparam int CORR_W = 31;
    localparam logic [CORR_W-1:0] CORR_MAX = {CORR_W{1'b1}};

    // Width and reset value of the minimum drive register (0.15 in Q0.15).
    localparam int MIN_DRIVE_W = 15;
    localparam logic [MIN_DRIVE_W-1:0] MIN_DRIVE_RESET = 15'd4915;

    // Default widths handed to the top level.
    localparam int DEF_SPEED_BITS = 16;
    localparam int DEF_COUNT_BITS = 16;
    localparam int DEF_CORRECTION_FRAC_BITS = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_CORR,
        ST_DIV_CORR,
        ST_WAIT_CORR,
        ST_ROOT,
        ST_WAIT_ROOT,
        ST_MUL_RIGHT,
        ST_DIV_LEFT,
        ST_WAIT_LEFT,
        ST_DRIVE,
        ST_OUT_STOP,
        ST_OUT_LAST
    } wrsd_state_t;

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        logic in_ready;
        logic mul_corr;
        logic mul_right;
        logic unit_start;
        logic unit_sqrt;
        logic unit_sel_left;
        logic cap_corr;
        logic cap_root;
        logic cap_left;
        logic cap_drive;
        logic out_valid;
        logic out_stop;
    } wrsd_ctl_t;

    // Status from the datapath and the ports to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic need_update;
        logic unit_done;
        logic dir_change;
        logic out_ready;
    } wrsd_stat_t;

endpackage

FILE: hdl/wheel_ratio_sync_drive_top.sv
// Wheel ratio synchronised drive. One input transfer per control tick carries
// the common speed command and the left and right encoder counts of the last
// tick; the block keeps a ratio correction (Q.CORRECTION_FRAC_BITS, kept in
// [1, 2^31-1]) and answers with one or two result transfers: right drive =
// speed*sqrt(correction), left drive = speed/sqrt(correction), negated when the
// right wheel is reversed. If either wheel would change direction a stop result
// (zero drives, pause flag set) is sent first. Every tick runs through one
// shared restoring divide/root unit, one bit per cycle for division and one
// root bit per cycle for the square root, plus one shared multiplier; the unit is
// 48 bits wide with the defaults. A tick skips the correction divide when the
// correction is not updated (restart, or a zero count). s_tready is high only
// while the block is idle, and it stays low
// until the last result of the tick has been taken. min_drive may be written
// at any idle time; it takes effect from the next tick.
module wheel_ratio_sync_drive_top #(
    parameter int SPEED_BITS           = wrsd_pkg::DEF_SPEED_BITS,
    parameter int COUNT_BITS           = wrsd_pkg::DEF_COUNT_BITS,
    parameter int CORRECTION_FRAC_BITS = wrsd_pkg::DEF_CORRECTION_FRAC_BITS,
    // Derived widths; not meant to be overridden.
    parameter int TDATA_IN_W  = ((SPEED_BITS + 2 * COUNT_BITS + 7) / 8) * 8,
    parameter int TDATA_OUT_W = ((2 * SPEED_BITS + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration: min_drive.
    input  logic                             cfg_wr_en,
    input  logic [wrsd_pkg::MIN_DRIVE_W-1:0] cfg_wr_data,
    // Input channel.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // From bit 0: speed_command, left_count, right_count, zero fill.
    input  logic [TDATA_IN_W-1:0]            s_tdata,
    // Bit 0: right_reversed, bit 1: restart.
    input  logic [1:0]                       s_tuser,
    // Result channel.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // From bit 0: left_drive, right_drive, zero fill.
    output logic [TDATA_OUT_W-1:0]           m_tdata,
    // Bit 0: pause_after, bit 1: correction_clipped.
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast
);

    localparam int F       = CORRECTION_FRAC_BITS;
    localparam int CORR_W  = wrsd_pkg::CORR_W;
    localparam int PROD_W  = CORR_W + COUNT_BITS;
    localparam int SQ_W    = CORR_W + F;
    localparam int LN_W    = SPEED_BITS + F;
    localparam int MAX_A   = (PROD_W > SQ_W) ? PROD_W : SQ_W;
    localparam int NUM_MAX = (MAX_A > LN_W) ? MAX_A : LN_W;
    // Unit width is kept even so the root takes whole bit pairs.
    localparam int N_W     = NUM_MAX + (NUM_MAX % 2);
    localparam int ROOT_W  = N_W / 2;
    localparam int D_W     = (COUNT_BITS > ROOT_W) ? COUNT_BITS : ROOT_W;
    localparam int MA_W    = (CORR_W > SPEED_BITS) ? CORR_W : SPEED_BITS;
    localparam int PR_W    = MA_W + D_W;
    localparam int SAT_W   = (N_W > PR_W) ? N_W : PR_W;
    localparam int MN_W    = (wrsd_pkg::MIN_DRIVE_W > SPEED_BITS) ?
                             wrsd_pkg::MIN_DRIVE_W : SPEED_BITS;
    localparam logic [MN_W-1:0] MAX_POS = MN_W'((64'd1 << (SPEED_BITS - 1)) - 64'd1);
    localparam logic [CORR_W-1:0] CORR_ONE = CORR_W'(64'd1 << F);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    wrsd_pkg::wrsd_ctl_t  ctl;
    wrsd_pkg::wrsd_stat_t stat;

    wrsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctl     (ctl)
    );

    // ------------------------------------------------------------------
    // Input unpacking and magnitudes.
    // ------------------------------------------------------------------
    logic [SPEED_BITS-1:0] in_speed;
    logic [COUNT_BITS-1:0] in_lcount;
    logic [COUNT_BITS-1:0] in_rcount;
    logic [SPEED_BITS-1:0] in_smag;
    logic [COUNT_BITS-1:0] in_lmag;
    logic [COUNT_BITS-1:0] in_rmag;
    logic                  in_accept;

    assign in_speed  = s_tdata[SPEED_BITS-1:0];
    assign in_lcount = s_tdata[SPEED_BITS +: COUNT_BITS];
    assign in_rcount = s_tdata[SPEED_BITS + COUNT_BITS +: COUNT_BITS];
    assign in_smag   = in_speed[SPEED_BITS-1] ? (~in_speed + 1'b1) : in_speed;
    assign in_lmag   = in_lcount[COUNT_BITS-1] ? (~in_lcount + 1'b1) : in_lcount;
    assign in_rmag   = in_rcount[COUNT_BITS-1] ? (~in_rcount + 1'b1) : in_rcount;
    assign in_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    logic [wrsd_pkg::MIN_DRIVE_W-1:0] min_drive_reg;
    logic [CORR_W-1:0]                corr_reg;
    logic                             clipped_reg;
    logic [SPEED_BITS-1:0]            smag_reg;
    logic                             sneg_reg;
    logic                             rev_reg;
    logic [COUNT_BITS-1:0]            lmag_reg;
    logic [COUNT_BITS-1:0]            rmag_reg;
    logic [PR_W-1:0]                  prod_reg;
    logic [ROOT_W-1:0]                root_reg;
    logic [N_W-1:0]                   lquot_reg;
    logic signed [SPEED_BITS-1:0]     last_left_reg;
    logic signed [SPEED_BITS-1:0]     last_right_reg;
    logic signed [SPEED_BITS-1:0]     drv_left_reg;
    logic signed [SPEED_BITS-1:0]     drv_right_reg;

    // ------------------------------------------------------------------
    // Shared multiplier: correction times |left count|, then |speed| times root.
    // ------------------------------------------------------------------
    logic [MA_W-1:0] mul_a;
    logic [D_W-1:0]  mul_b;
    logic [PR_W-1:0] mul_p;

    assign mul_a = ctl.mul_right ? MA_W'(smag_reg) : MA_W'(corr_reg);
    assign mul_b = ctl.mul_right ? D_W'(root_reg) : D_W'(lmag_reg);
    assign mul_p = PR_W'(mul_a) * PR_W'(mul_b);

    // ------------------------------------------------------------------
    // Shared divide / square root unit.
    // ------------------------------------------------------------------
    logic [N_W-1:0] unit_num;
    logic [D_W-1:0] unit_den;
    logic [N_W-1:0] unit_quot;
    logic           unit_done;

    always_comb begin
        if (ctl.unit_sqrt) begin
            unit_num = N_W'({corr_reg, {F{1'b0}}});
        end else if (ctl.unit_sel_left) begin
            unit_num = N_W'({smag_reg, {F{1'b0}}});
        end else begin
            unit_num = N_W'(prod_reg[PROD_W-1:0]);
        end
        unit_den = ctl.unit_sel_left ? D_W'(root_reg) : D_W'(rmag_reg);
    end

    wrsd_divsqrt #(
        .N_W (N_W),
        .D_W (D_W)
    ) u_divsqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ctl.unit_start),
        .mode_sqrt (ctl.unit_sqrt),
        .num       (unit_num),
        .den       (unit_den),
        .done      (unit_done),
        .quot      (unit_quot)
    );

    // ------------------------------------------------------------------
    // Drive saturation, direction change and minimum raise.
    // ------------------------------------------------------------------
    function automatic logic [SPEED_BITS-1:0] sat_drive(input logic [SAT_W-1:0] m,
                                                        input logic neg);
        logic [SAT_W-1:0]      lim;
        logic [SAT_W-1:0]      mm;
        logic [SPEED_BITS-1:0] t;
        lim = SAT_W'(1) << (SPEED_BITS - 1);
        if (neg) begin
            mm = (m > lim) ? lim : m;
            t  = SPEED_BITS'(mm);
            return ~t + 1'b1;
        end else begin
            mm = (m > lim - 1'b1) ? (lim - 1'b1) : m;
            return SPEED_BITS'(mm);
        end
    endfunction

    logic [MN_W-1:0]       min_wide;
    logic [SPEED_BITS-1:0] min_eff;

    assign min_wide = (MN_W'(min_drive_reg) > MAX_POS) ? MAX_POS : MN_W'(min_drive_reg);
    assign min_eff  = SPEED_BITS'(min_wide);

    function automatic logic [SPEED_BITS-1:0] raise_min(input logic [SPEED_BITS-1:0] v,
                                                        input logic [SPEED_BITS-1:0] mn);
        logic [SPEED_BITS-1:0] mag;
        mag = v[SPEED_BITS-1] ? (~v + 1'b1) : v;
        if ((v != '0) && (mag < mn)) begin
            return v[SPEED_BITS-1] ? (~mn + 1'b1) : mn;
        end
        return v;
    endfunction

    logic signed [SPEED_BITS-1:0] new_right;
    logic signed [SPEED_BITS-1:0] new_left;
    logic                         dir_change;

    assign new_right = sat_drive(SAT_W'(prod_reg >> F), sneg_reg);
    assign new_left  = sat_drive(SAT_W'(lquot_reg), sneg_reg ^ rev_reg);
    assign dir_change = ((new_left < 0) && (last_left_reg > 0)) ||
                        ((new_left > 0) && (last_left_reg < 0)) ||
                        ((new_right < 0) && (last_right_reg > 0)) ||
                        ((new_right > 0) && (last_right_reg < 0));

    // ------------------------------------------------------------------
    // Status to the sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        stat.in_valid    = s_tvalid;
        stat.need_update = !s_tuser[1] && (in_lcount != '0) && (in_rcount != '0);
        stat.unit_done   = unit_done;
        stat.dir_change  = dir_change;
        stat.out_ready   = m_tready;
    end

    // ------------------------------------------------------------------
    // Register updates.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            smag_reg <= in_smag;
            sneg_reg <= in_speed[SPEED_BITS-1];
            rev_reg  <= s_tuser[0];
            lmag_reg <= in_lmag;
            rmag_reg <= in_rmag;
        end
        if (ctl.mul_corr || ctl.mul_right) begin
            prod_reg <= mul_p;
        end
        if (ctl.cap_root) begin
            root_reg <= (unit_quot == '0) ? ROOT_W'(1) : ROOT_W'(unit_quot);
        end
        if (ctl.cap_left) begin
            lquot_reg <= unit_quot;
        end
        if (ctl.cap_drive) begin
            drv_left_reg  <= raise_min(new_left, min_eff);
            drv_right_reg <= raise_min(new_right, min_eff);
        end
    end

    // State kept across ticks, and the configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_drive_reg  <= wrsd_pkg::MIN_DRIVE_RESET;
            corr_reg       <= CORR_ONE;
            clipped_reg    <= 1'b0;
            last_left_reg  <= '0;
            last_right_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                min_drive_reg <= cfg_wr_data;
            end
            if (in_accept) begin
                clipped_reg <= 1'b0;
                if (s_tuser[1]) begin
                    corr_reg <= CORR_ONE;
                end
            end
            if (ctl.cap_corr) begin
                if (unit_quot > N_W'(wrsd_pkg::CORR_MAX)) begin
                    corr_reg    <= wrsd_pkg::CORR_MAX;
                    clipped_reg <= 1'b1;
                end else if (unit_quot == '0) begin
                    corr_reg    <= CORR_W'(1);
                    clipped_reg <= 1'b1;
                end else begin
                    corr_reg <= CORR_W'(unit_quot);
                end
            end
            if (ctl.cap_drive) begin
                if (dir_change) begin
                    last_left_reg  <= '0;
                    last_right_reg <= '0;
                end else begin
                    last_left_reg  <= new_left;
                    last_right_reg <= new_right;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Ports. The stop result carries zero drives and the pause request; the
    // drive result closes the tick with tlast. No input transfer is taken
    // while reset is held.
    // ------------------------------------------------------------------
    assign s_tready = ctl.in_ready && aresetn;
    assign m_tvalid = ctl.out_valid;
    assign m_tdata  = ctl.out_stop ? '0 : TDATA_OUT_W'({drv_right_reg, drv_left_reg});
    assign m_tuser  = {clipped_reg, ctl.out_stop};
    assign m_tlast  = !ctl.out_stop;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("result offered while the block takes input");

    a_corr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        corr_reg != '0)
        else $error("correction reached zero");

    a_stop_then_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tuser[0]) |=> (m_tvalid && m_tlast))
        else $error("stop transfer not followed by the drive result");

    a_done_captured: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_done |-> (ctl.cap_corr || ctl.cap_root || ctl.cap_left))
        else $error("divide/root result finished outside a wait state");

    a_restart_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[1]) |=> (corr_reg == CORR_ONE))
        else $error("restart did not reset the correction");

endmodule

FILE: hdl/wrsd_divsqrt.sv
// Shared restoring divide and square root unit. Division retires one quotient
// bit per cycle, N_W bits in all; square root retires one root bit per cycle,
// N_W/2 bits in all. Both use the same compare and subtract.
module wrsd_divsqrt #(
    parameter int N_W = 48,
    parameter int D_W = 24
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic           mode_sqrt,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic           done,
    output logic [N_W-1:0] quot
);

    localparam int R_W = D_W + 3;
    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   num_reg,  num_next;
    logic [N_W-1:0]   quot_reg, quot_next;
    logic [R_W-1:0]   rem_reg,  rem_next;
    logic [D_W-1:0]   den_reg;
    logic             sqrt_reg;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [R_W-1:0] shifted;
    logic [R_W-1:0] trial;
    logic [R_W-1:0] diff;
    logic           ge;

    always_comb begin
        if (sqrt_reg) begin
            shifted = {rem_reg[R_W-3:0], num_reg[N_W-1:N_W-2]};
            trial   = {quot_reg[R_W-3:0], 2'b01};
        end else begin
            shifted = {rem_reg[R_W-2:0], num_reg[N_W-1]};
            trial   = R_W'(den_reg);
        end
        ge   = (shifted >= trial);
        diff = shifted - trial;
    end

    always_comb begin
        num_next  = num_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = num;
            quot_next = '0;
            rem_next  = '0;
            cnt_next  = mode_sqrt ? CNT_W'(N_W / 2) : CNT_W'(N_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next  = sqrt_reg ? {num_reg[N_W-3:0], 2'b00} : {num_reg[N_W-2:0], 1'b0};
            quot_next = {quot_reg[N_W-2:0], ge};
            rem_next  = ge ? diff : shifted;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start) begin
            den_reg  <= den;
            sqrt_reg <= mode_sqrt;
        end
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: hdl/wrsd_ctrl.sv
// Sequencer: optional multiply/divide, then root, multiply, divide and output.
module wrsd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wrsd_pkg::wrsd_stat_t stat,
    output wrsd_pkg::wrsd_ctl_t  ctl
);

    wrsd_pkg::wrsd_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wrsd_pkg::ST_IDLE: begin
                if (stat.in_valid) begin
                    state_next = stat.need_update ? wrsd_pkg::ST_MUL_CORR : wrsd_pkg::ST_ROOT;
                end
            end
            wrsd_pkg::ST_MUL_CORR:  state_next = wrsd_pkg::ST_DIV_CORR;
            wrsd_pkg::ST_DIV_CORR:  state_next = wrsd_pkg::ST_WAIT_CORR;
            wrsd_pkg::ST_WAIT_CORR: begin
                if (stat.unit_done) begin
                    state_next = wrsd_pkg::ST_ROOT;
                end
            end
            wrsd_pkg::ST_ROOT:      state_next = wrsd_pkg::ST_WAIT_ROOT;
            wrsd_pkg::ST_WAIT_ROOT: begin
                if (stat.unit_done) begin
                    state_next = wrsd_pkg::ST_MUL_RIGHT;
                end
            end
            wrsd_pkg::ST_MUL_RIGHT: state_next = wrsd_pkg::ST_DIV_LEFT;
            wrsd_pkg::ST_DIV_LEFT:  state_next = wrsd_pkg::ST_WAIT_LEFT;
            wrsd_pkg::ST_WAIT_LEFT: begin
                if (stat.unit_done) begin
                    state_next = wrsd_pkg::ST_DRIVE;
                end
            end
            wrsd_pkg::ST_DRIVE: begin
                state_next = stat.dir_change ? wrsd_pkg::ST_OUT_STOP : wrsd_pkg::ST_OUT_LAST;
            end
            wrsd_pkg::ST_OUT_STOP: begin
                if (stat.out_ready) begin
                    state_next = wrsd_pkg::ST_OUT_LAST;
                end
            end
            wrsd_pkg::ST_OUT_LAST: begin
                if (stat.out_ready) begin
                    state_next = wrsd_pkg::ST_IDLE;
                end
            end
            default: state_next = wrsd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        unique case (state_reg)
            wrsd_pkg::ST_IDLE:      ctl.in_ready = 1'b1;
            wrsd_pkg::ST_MUL_CORR:  ctl.mul_corr = 1'b1;
            wrsd_pkg::ST_DIV_CORR:  ctl.unit_start = 1'b1;
            wrsd_pkg::ST_WAIT_CORR: ctl.cap_corr = stat.unit_done;
            wrsd_pkg::ST_ROOT: begin
                ctl.unit_start = 1'b1;
                ctl.unit_sqrt  = 1'b1;
            end
            wrsd_pkg::ST_WAIT_ROOT: ctl.cap_root = stat.unit_done;
            wrsd_pkg::ST_MUL_RIGHT: ctl.mul_right = 1'b1;
            wrsd_pkg::ST_DIV_LEFT: begin
                ctl.unit_start    = 1'b1;
                ctl.unit_sel_left = 1'b1;
            end
            wrsd_pkg::ST_WAIT_LEFT: ctl.cap_left = stat.unit_done;
            wrsd_pkg::ST_DRIVE:     ctl.cap_drive = 1'b1;
            wrsd_pkg::ST_OUT_STOP: begin
                ctl.out_valid = 1'b1;
                ctl.out_stop  = 1'b1;
            end
            wrsd_pkg::ST_OUT_LAST:  ctl.out_valid = 1'b1;
            default:                ctl = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wrsd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
